// ===== rtl/dlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed linear ramp package
// Widths, register indexes, micro-op codes and the microcode program that
// the ramp sequencer steps through.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Field and datapath widths.
    localparam int LEVEL_W    = 16;
    localparam int TICK_W     = 16;
    localparam int TIME_W     = 24;
    localparam int ELAPSED_W  = TIME_W + 1;
    localparam int QUOT_W     = LEVEL_W;
    localparam int PROD_W     = TIME_W + QUOT_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int PC_W       = 4;
    localparam int LOOP_W     = $clog2(QUOT_W);

    // Loop count for the restoring divider: one quotient bit per pass.
    localparam logic [LOOP_W-1:0] DIV_LAST = LOOP_W'(QUOT_W - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_LEVEL = 4'd0,
        REG_END_LEVEL   = 4'd1,
        REG_RAMP_TICKS  = 4'd2,
        REG_START_DELAY = 4'd3
    } cfg_reg_t;

    typedef logic [PC_W-1:0] pc_t;

    // Microcode step addresses.
    localparam pc_t PC_WAIT      = 4'd0;
    localparam pc_t PC_DISPATCH  = 4'd1;
    localparam pc_t PC_DELAY_CHK = 4'd2;
    localparam pc_t PC_DELAY_SUB = 4'd3;
    localparam pc_t PC_ADD       = 4'd4;
    localparam pc_t PC_DONE_CHK  = 4'd5;
    localparam pc_t PC_MUL       = 4'd6;
    localparam pc_t PC_DIV_INIT  = 4'd7;
    localparam pc_t PC_DIV_STEP  = 4'd8;
    localparam pc_t PC_INTERP    = 4'd9;
    localparam pc_t PC_FINISH    = 4'd10;
    localparam pc_t PC_EMIT      = 4'd11;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_ACCEPT    = 4'd1,
        OP_DELAY_SUB = 4'd2,
        OP_ADD       = 4'd3,
        OP_MUL       = 4'd4,
        OP_DIV_INIT  = 4'd5,
        OP_DIV_STEP  = 4'd6,
        OP_INTERP    = 4'd7,
        OP_FINISH    = 4'd8,
        OP_EMIT      = 4'd9
    } op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_ALWAYS    = 3'd1,
        C_IN_FIRE   = 3'd2,
        C_INACTIVE  = 3'd3,
        C_NO_DELAY  = 3'd4,
        C_DONE      = 3'd5,
        C_LOOP_MORE = 3'd6,
        C_OUT_FREE  = 3'd7
    } cond_t;

    // One control word. A taken condition jumps to target; otherwise the
    // step either holds in place or falls through to the next address.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        logic  hold;
        logic  loop_load;
        pc_t   target;
    } ctrl_t;

    // Status flags from the datapath that the conditions test.
    typedef struct packed {
        logic in_fire;
        logic active;
        logic delay_pending;
        logic done;
        logic out_free;
    } seq_status_t;

    function automatic ctrl_t cw(input op_t op, input cond_t cond, input logic hold,
                                 input logic loop_load, input pc_t target);
        ctrl_t w;
        w.op        = op;
        w.cond      = cond;
        w.hold      = hold;
        w.loop_load = loop_load;
        w.target    = target;
        return w;
    endfunction

    // The ramp program.
    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        unique case (pc)
            PC_WAIT:      w = cw(OP_ACCEPT,    C_IN_FIRE,   1'b1, 1'b0, PC_DISPATCH);
            PC_DISPATCH:  w = cw(OP_NOP,       C_INACTIVE,  1'b0, 1'b0, PC_EMIT);
            PC_DELAY_CHK: w = cw(OP_NOP,       C_NO_DELAY,  1'b0, 1'b0, PC_ADD);
            PC_DELAY_SUB: w = cw(OP_DELAY_SUB, C_ALWAYS,    1'b0, 1'b0, PC_EMIT);
            PC_ADD:       w = cw(OP_ADD,       C_NEVER,     1'b0, 1'b0, PC_WAIT);
            PC_DONE_CHK:  w = cw(OP_NOP,       C_DONE,      1'b0, 1'b0, PC_FINISH);
            PC_MUL:       w = cw(OP_MUL,       C_NEVER,     1'b0, 1'b0, PC_WAIT);
            PC_DIV_INIT:  w = cw(OP_DIV_INIT,  C_NEVER,     1'b0, 1'b1, PC_WAIT);
            PC_DIV_STEP:  w = cw(OP_DIV_STEP,  C_LOOP_MORE, 1'b0, 1'b0, PC_DIV_STEP);
            PC_INTERP:    w = cw(OP_INTERP,    C_ALWAYS,    1'b0, 1'b0, PC_EMIT);
            PC_FINISH:    w = cw(OP_FINISH,    C_NEVER,     1'b0, 1'b0, PC_WAIT);
            PC_EMIT:      w = cw(OP_EMIT,      C_OUT_FREE,  1'b1, 1'b0, PC_WAIT);
            default:      w = cw(OP_NOP,       C_ALWAYS,    1'b0, 1'b0, PC_WAIT);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/dlr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed linear ramp channels
// Valid/ready interfaces for the tick input, the level output and the
// configuration write port.
// ----------------------------------------------------------------------------
interface dlr_tick_if;
    import dlr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] tick_step;

    modport source (output valid, output tick_step, input ready);
    modport sink   (input valid, input tick_step, output ready);
endinterface

interface dlr_level_if;
    import dlr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level_out;
    logic                      running;

    modport source (output valid, output level_out, output running, input ready);
    modport sink   (input valid, input level_out, input running, output ready);
endinterface

interface dlr_cfg_if;
    import dlr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dlr_useq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed linear ramp microcode sequencer
// Step counter, loop counter and program table; issues one control word
// per cycle to the ramp datapath.
// ----------------------------------------------------------------------------
module dlr_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dlr_pkg::seq_status_t status,
    output dlr_pkg::ctrl_t       ctrl
);
    import dlr_pkg::*;

    pc_t               pc_reg;
    pc_t               pc_next;
    logic [LOOP_W-1:0] cnt_reg;
    logic [LOOP_W-1:0] cnt_next;
    logic              take;

    // Control word of the current step.
    assign ctrl = ucode_rom(pc_reg);

    // Condition select.
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_IN_FIRE:   take = status.in_fire;
            C_INACTIVE:  take = !status.active;
            C_NO_DELAY:  take = !status.delay_pending;
            C_DONE:      take = status.done;
            C_LOOP_MORE: take = (cnt_reg != '0);
            C_OUT_FREE:  take = status.out_free;
            default:     take = 1'b0;
        endcase
    end

    // Next step address and loop count.
    always_comb
    begin
        if (take)
        begin
            pc_next = ctrl.target;
        end
        else if (ctrl.hold)
        begin
            pc_next = pc_reg;
        end
        else
        begin
            pc_next = pc_reg + pc_t'(1);
        end

        cnt_next = cnt_reg;
        if (ctrl.loop_load)
        begin
            cnt_next = DIV_LAST;
        end
        else if (ctrl.cond == C_LOOP_MORE && take)
        begin
            cnt_next = cnt_reg - LOOP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_WAIT;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    // A blocked result keeps the sequencer parked on the emit step.
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_EMIT && !status.out_free) |=> (pc_reg == PC_EMIT))
        else $error("sequencer left emit step while output was blocked");

    // The divide loop exits to the interpolation step once the count runs out.
    a_loop_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_DIV_STEP && cnt_reg == '0) |=> (pc_reg == PC_INTERP))
        else $error("divide loop did not exit on a zero count");

    // Loading the loop count leads straight into the divide loop.
    a_loop_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.loop_load |=> (pc_reg == PC_DIV_STEP && cnt_reg == DIV_LAST))
        else $error("divide loop entered with a wrong count");

endmodule

// ===== rtl/delayed_linear_ramp_top.sv =====
`timescale 1ns / 1ps
// Per tick word: wait, dispatch, then emit if the ramp has finished; else delay
// check, then subtract during the start delay, or add, done check and finish or
// multiply, divide init, 16 divide passes and interpolate; emit holds if blocked.
// One word is in work at a time; the next is taken once the result is loaded
// into the output register, while that result still waits to be taken.
// Reset: ramp armed with start 0, end 0, duration 1, delay 0; no output valid.
// ----------------------------------------------------------------------------
// Delayed linear ramp top level
// Timed linear ramp in signed Q8.8 with a start delay, driven by a
// microcoded sequencer over a multiply and shift-subtract datapath.
// ----------------------------------------------------------------------------
module delayed_linear_ramp_top (
    input logic         clk,
    input logic         rst_n,
    dlr_tick_if.sink    tick,
    dlr_level_if.source level,
    dlr_cfg_if.sink     cfg
);
    import dlr_pkg::*;

    // Configuration registers.
    logic signed [LEVEL_W-1:0] start_level_reg;
    logic signed [LEVEL_W-1:0] end_level_reg;
    logic [TIME_W-1:0]         ramp_ticks_reg;
    logic [TIME_W-1:0]         start_delay_reg;
    logic signed [LEVEL_W-1:0] start_level_next;
    logic signed [LEVEL_W-1:0] end_level_next;
    logic [TIME_W-1:0]         ramp_ticks_next;
    logic [TIME_W-1:0]         start_delay_next;

    // Ramp state.
    logic [TIME_W-1:0]         delay_left_reg;
    logic [ELAPSED_W-1:0]      elapsed_reg;
    logic                      active_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic [TIME_W-1:0]         delay_left_next;
    logic [ELAPSED_W-1:0]      elapsed_next;
    logic                      active_next;
    logic signed [LEVEL_W-1:0] level_next;

    // Work registers.
    logic [TICK_W-1:0]         step_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [TIME_W-1:0]         rem_reg;
    logic [QUOT_W-1:0]         quot_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [LEVEL_W-1:0] out_level_reg;
    logic                      out_running_reg;

    ctrl_t                     ctrl;
    seq_status_t               status;
    logic                      in_fire;
    logic                      cfg_fire;
    logic                      cfg_rearm;
    logic                      out_free;
    logic                      emit_load;

    logic signed [LEVEL_W:0]   diff;
    logic signed [LEVEL_W:0]   diff_abs;
    logic                      diff_neg;
    logic [LEVEL_W-1:0]        mag;
    logic [TIME_W-1:0]         elapsed_lo;
    logic [PROD_W-1:0]         prod_full;
    logic [TIME_W:0]           div_part;
    logic [TIME_W:0]           div_diff;
    logic                      div_ge;
    logic signed [LEVEL_W:0]   quot_ext;
    logic signed [LEVEL_W:0]   interp_sum;

    dlr_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // Handshakes: words and configuration are taken only on the wait step.
    assign tick.ready = (ctrl.op == OP_ACCEPT);
    assign cfg.ready  = (ctrl.op == OP_ACCEPT);
    assign in_fire    = tick.valid && tick.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign out_free   = !out_valid_reg || level.ready;
    assign emit_load  = (ctrl.op == OP_EMIT) && out_free;

    assign level.valid     = out_valid_reg;
    assign level.level_out = out_level_reg;
    assign level.running   = out_running_reg;

    // Status flags for the sequencer.
    always_comb
    begin
        status.in_fire       = in_fire;
        status.active        = active_reg;
        status.delay_pending = (delay_left_reg != '0);
        status.done          = ({1'b0, ramp_ticks_reg} <= elapsed_reg);
        status.out_free      = out_free;
    end

    // Span of the ramp as sign and magnitude.
    always_comb
    begin
        diff       = {end_level_reg[LEVEL_W-1], end_level_reg}
                   - {start_level_reg[LEVEL_W-1], start_level_reg};
        diff_neg   = diff[LEVEL_W];
        diff_abs   = diff_neg ? -diff : diff;
        mag        = diff_abs[LEVEL_W-1:0];
        elapsed_lo = elapsed_reg[TIME_W-1:0];
        prod_full  = elapsed_lo * mag;
    end

    // One restoring divide pass: shift in the next dividend bit, subtract.
    always_comb
    begin
        div_part = {rem_reg, quot_reg[QUOT_W-1]};
        div_diff = div_part - {1'b0, ramp_ticks_reg};
        div_ge   = (div_part >= {1'b0, ramp_ticks_reg});
    end

    // Truncated quotient applied toward the end level.
    always_comb
    begin
        quot_ext   = $signed({1'b0, quot_reg});
        interp_sum = {start_level_reg[LEVEL_W-1], start_level_reg}
                   + (diff_neg ? -quot_ext : quot_ext);
    end

    // Configuration writes; a known index re-arms the ramp.
    always_comb
    begin
        start_level_next = start_level_reg;
        end_level_next   = end_level_reg;
        ramp_ticks_next  = ramp_ticks_reg;
        start_delay_next = start_delay_reg;
        cfg_rearm        = 1'b0;
        if (cfg_fire)
        begin
            if (cfg.index == REG_START_LEVEL)
            begin
                start_level_next = $signed(cfg.data[LEVEL_W-1:0]);
                cfg_rearm        = 1'b1;
            end
            if (cfg.index == REG_END_LEVEL)
            begin
                end_level_next = $signed(cfg.data[LEVEL_W-1:0]);
                cfg_rearm      = 1'b1;
            end
            if (cfg.index == REG_RAMP_TICKS)
            begin
                ramp_ticks_next = cfg.data[TIME_W-1:0];
                cfg_rearm       = 1'b1;
            end
            if (cfg.index == REG_START_DELAY)
            begin
                start_delay_next = cfg.data[TIME_W-1:0];
                cfg_rearm        = 1'b1;
            end
        end
    end

    // Ramp state update per micro-op.
    always_comb
    begin
        delay_left_next = delay_left_reg;
        elapsed_next    = elapsed_reg;
        active_next     = active_reg;
        level_next      = level_reg;
        unique case (ctrl.op)
            OP_DELAY_SUB:
            begin
                if (TIME_W'(step_reg) >= delay_left_reg)
                begin
                    delay_left_next = '0;
                end
                else
                begin
                    delay_left_next = delay_left_reg - TIME_W'(step_reg);
                end
            end
            OP_ADD:
            begin
                elapsed_next = elapsed_reg + ELAPSED_W'(step_reg);
            end
            OP_INTERP:
            begin
                level_next = interp_sum[LEVEL_W-1:0];
            end
            OP_FINISH:
            begin
                level_next  = end_level_reg;
                active_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (cfg_rearm)
        begin
            delay_left_next = start_delay_next;
            elapsed_next    = '0;
            active_next     = 1'b1;
            level_next      = start_level_next;
        end
    end

    // Configuration and ramp state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_level_reg <= '0;
            end_level_reg   <= '0;
            ramp_ticks_reg  <= TIME_W'(1);
            start_delay_reg <= '0;
            delay_left_reg  <= '0;
            elapsed_reg     <= '0;
            active_reg      <= 1'b1;
            level_reg       <= '0;
        end
        else
        begin
            start_level_reg <= start_level_next;
            end_level_reg   <= end_level_next;
            ramp_ticks_reg  <= ramp_ticks_next;
            start_delay_reg <= start_delay_next;
            delay_left_reg  <= delay_left_next;
            elapsed_reg     <= elapsed_next;
            active_reg      <= active_next;
            level_reg       <= level_next;
        end
    end

    // Work registers: latched tick, product, remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            step_reg <= tick.tick_step;
        end
        if (ctrl.op == OP_MUL)
        begin
            prod_reg <= prod_full;
        end
        if (ctrl.op == OP_DIV_INIT)
        begin
            rem_reg  <= prod_reg[PROD_W-1 -: TIME_W];
            quot_reg <= prod_reg[QUOT_W-1:0];
        end
        else if (ctrl.op == OP_DIV_STEP)
        begin
            rem_reg  <= div_ge ? div_diff[TIME_W-1:0] : div_part[TIME_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], div_ge};
        end
        if (emit_load)
        begin
            out_level_reg   <= level_next;
            out_running_reg <= active_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (level.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // A write to a known register leaves the ramp armed from zero.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_fire && (cfg.index == REG_START_LEVEL || cfg.index == REG_END_LEVEL
            || cfg.index == REG_RAMP_TICKS || cfg.index == REG_START_DELAY))
        |=> (active_reg && elapsed_reg == '0))
        else $error("configuration write did not re-arm the ramp");

    // The quotient never exceeds the span, so the level stays between the ends.
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_INTERP) |-> (quot_reg <= mag))
        else $error("interpolation quotient beyond ramp span");

    // Elapsed time only builds up after the start delay has run out.
    a_delay_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (delay_left_reg != '0) |-> (elapsed_reg == '0))
        else $error("elapsed time advanced during the start delay");

endmodule
